### hw/rtl/b62dc_pkg.sv
// ----------------------------------------------------------------------------
// b62dc_pkg: shared types and constants of the base-62 digit counter
// Request and response payloads, cell operation codes and the digit-to-ASCII
// mapping for the alphabet 0-9, a-z, A-Z.
// ----------------------------------------------------------------------------
package b62dc_pkg;

   // field widths
   localparam int DIGIT_W   = 6;
   localparam int VALUE_W   = 32;
   localparam int CHAR_W    = 7;
   localparam int LIMIT_W   = 4;
   localparam int BIT_CNT_W = 5;

   // bit counter value of the last load step
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = 5'd31;

   // reset value of the digit limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   // digit arithmetic
   localparam logic [DIGIT_W:0]   RADIX      = 7'd62;
   localparam logic [DIGIT_W-1:0] TOP_DIGIT  = 6'd61;
   localparam logic [DIGIT_W-1:0] HALF_RADIX = 6'd31;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 6'd1;

   // alphabet boundaries
   localparam logic [DIGIT_W-1:0] FIRST_LOWER = 6'd10;
   localparam logic [DIGIT_W-1:0] FIRST_UPPER = 6'd36;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0]  LOWER_BIAS  = 7'd87;
   localparam logic [CHAR_W-1:0]  UPPER_BIAS  = 7'd29;

   // request operation codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_INC  = 1'b1;

   // cell operation codes
   localparam logic [2:0] OP_HOLD   = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_SHIFT  = 3'd2;
   localparam logic [2:0] OP_INC    = 3'd3;
   localparam logic [2:0] OP_ROTATE = 3'd4;

   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              final_char;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic [2:0] op;
      logic       live;     // cell lies below the digit limit
      logic       in_num;   // cell lies below the current digit count
   } cell_ctl_type;

   // map a digit to its ASCII character; codes above the top digit read as '0'
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (d < FIRST_LOWER) begin
         glyph = wide + CHAR_ZERO;
      end else if (d < FIRST_UPPER) begin
         glyph = wide + LOWER_BIAS;
      end else if (d <= TOP_DIGIT) begin
         glyph = wide + UPPER_BIAS;
      end else begin
         glyph = CHAR_ZERO;
      end
   endfunction

endpackage

### hw/rtl/b62dc_cell.sv
// ----------------------------------------------------------------------------
// b62dc_cell: one base-62 digit of the counter chain
// Holds one digit and trades a carry or a digit with its lower neighbor each
// cycle: doubling with carry-in for binary conversion, ripple increment with
// a registered carry, and rotation for most-significant-first readout.
// ----------------------------------------------------------------------------
module b62dc_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  b62dc_pkg::cell_ctl_type         ctl,
   input  logic                            nb_carry,
   input  logic [b62dc_pkg::DIGIT_W-1:0]   nb_digit,
   output logic [b62dc_pkg::DIGIT_W-1:0]   digit,
   output logic                            dbl_carry,
   output logic                            inc_carry
);

   logic [b62dc_pkg::DIGIT_W-1:0] digit_ff, digit_in;
   logic                          carry_ff, carry_in;
   logic [b62dc_pkg::DIGIT_W:0]   twice;

   // a digit of 31 or more overflows when doubled, whatever comes in
   assign dbl_carry = digit_ff >= b62dc_pkg::HALF_RADIX;
   assign twice     = {digit_ff, nb_carry};
   assign digit     = digit_ff;
   assign inc_carry = carry_ff;

   // next digit and increment carry
   always_comb begin
      digit_in = digit_ff;
      carry_in = 1'b0;
      unique case (ctl.op)
         b62dc_pkg::OP_CLEAR: begin
            digit_in = '0;
         end
         b62dc_pkg::OP_SHIFT: begin
            if (ctl.live) begin
               if (dbl_carry) begin
                  digit_in = b62dc_pkg::DIGIT_W'(twice - b62dc_pkg::RADIX);
               end else begin
                  digit_in = twice[b62dc_pkg::DIGIT_W-1:0];
               end
            end
         end
         b62dc_pkg::OP_INC: begin
            // digits of the number always take the carry, even above the limit
            if ((ctl.live || ctl.in_num) && nb_carry) begin
               if (digit_ff >= b62dc_pkg::TOP_DIGIT) begin
                  digit_in = '0;
                  carry_in = 1'b1;
               end else begin
                  digit_in = digit_ff + b62dc_pkg::DIGIT_ONE;
               end
            end
         end
         b62dc_pkg::OP_ROTATE: begin
            if (ctl.in_num) begin
               digit_in = nb_digit;
            end
         end
         default: begin
            digit_in = digit_ff;
         end
      endcase
   end

   // hold the digit; clear the carry on reset
   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      if (reset) begin
         carry_ff <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
   end

endmodule

### hw/rtl/base62_digit_counter.sv
// ----------------------------------------------------------------------------
// base62_digit_counter: base-62 counter with string readout
// Load: accept, shift the 32-bit value into the cell row one bit per cycle,
// then send N characters. Increment: accept, ripple the carry through the
// wrapped digits, then send N characters; an empty number becomes one '0'.
// Characters are registered; requests stall until the last one is issued.
// Synchronous reset empties the number, sets the limit to 8 and idles.
// ----------------------------------------------------------------------------
module base62_digit_counter #(
   parameter int MAX_DIGITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  b62dc_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output b62dc_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [b62dc_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int LW = (CW > b62dc_pkg::LIMIT_W) ? CW : b62dc_pkg::LIMIT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_INC  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [b62dc_pkg::LIMIT_W-1:0]       limit_ff;
   logic [b62dc_pkg::VALUE_W-1:0]       shift_ff, shift_in;
   logic [b62dc_pkg::BIT_CNT_W-1:0]     bitcnt_ff, bitcnt_in;
   logic [CW-1:0]                       emit_ff, emit_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   b62dc_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [LW-1:0]                       lim_one;
   logic [CW-1:0]                       lim_eff;
   logic                                req_accept;
   logic                                out_free;
   logic                                emit_last;
   logic [2:0]                          cell_op;
   logic                                cell0_carry;

   logic [b62dc_pkg::DIGIT_W-1:0]       cell_digit [MAX_DIGITS];
   logic [MAX_DIGITS-1:0]               dbl_vec;
   logic [MAX_DIGITS-1:0]               inc_vec;
   logic [MAX_DIGITS-1:0]               top_hit;
   logic [MAX_DIGITS-1:0]               live_vec;
   logic [MAX_DIGITS-1:0]               num_vec;
   logic [b62dc_pkg::DIGIT_W-1:0]       top_digit;
   logic                                dbl_top;
   logic                                inc_top;

   // handshakes
   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // clamp the limit to 1..MAX_DIGITS
   always_comb begin
      lim_one = (limit_ff == '0) ? LW'(1) : LW'(limit_ff);
      lim_eff = (lim_one > LW'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(lim_one);
   end

   // decode cell positions and pick the most significant digit
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         top_hit[i]  = count_ff == CW'(i + 1);
         live_vec[i] = CW'(i) < lim_eff;
         num_vec[i]  = CW'(i) < count_ff;
         top_digit   = top_digit | (top_hit[i] ? cell_digit[i] : '0);
      end
      dbl_top = |(dbl_vec & top_hit);
      inc_top = |(inc_vec & top_hit);
   end

   assign emit_last   = CW'(emit_ff + CW'(1)) == count_ff;
   assign cell0_carry = (cell_op == b62dc_pkg::OP_SHIFT) ? shift_ff[b62dc_pkg::VALUE_W-1]
                                                         : (state_ff == S_IDLE);

   // row of digit cells, least significant at index 0
   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      b62dc_pkg::cell_ctl_type       ctl;
      logic                          nb_carry;
      logic [b62dc_pkg::DIGIT_W-1:0] nb_digit;

      assign ctl.op     = cell_op;
      assign ctl.live   = live_vec[g];
      assign ctl.in_num = num_vec[g];

      if (g == 0) begin : g_first
         assign nb_carry = cell0_carry;
         assign nb_digit = top_digit;
      end else begin : g_rest
         assign nb_carry = (cell_op == b62dc_pkg::OP_SHIFT) ? dbl_vec[g-1] : inc_vec[g-1];
         assign nb_digit = cell_digit[g-1];
      end

      b62dc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .nb_carry  (nb_carry),
         .nb_digit  (nb_digit),
         .digit     (cell_digit[g]),
         .dbl_carry (dbl_vec[g]),
         .inc_carry (inc_vec[g])
      );
   end

   // sequencer: load, increment, readout
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      bitcnt_in    = bitcnt_ff;
      emit_in      = emit_ff;
      cell_op      = b62dc_pkg::OP_HOLD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.func == b62dc_pkg::FUNC_LOAD || count_ff == '0) begin
                  cell_op  = b62dc_pkg::OP_CLEAR;
                  count_in = CW'(1);
                  if (req_data.func == b62dc_pkg::FUNC_LOAD) begin
                     state_in  = S_LOAD;
                     shift_in  = req_data.load_value;
                     bitcnt_in = '0;
                  end else begin
                     state_in = S_EMIT;
                     emit_in  = '0;
                  end
               end else begin
                  cell_op  = b62dc_pkg::OP_INC;
                  state_in = S_INC;
               end
            end
         end
         S_LOAD: begin
            // shift one value bit into the row, most significant first
            cell_op   = b62dc_pkg::OP_SHIFT;
            shift_in  = shift_ff << 1;
            bitcnt_in = bitcnt_ff + 1'b1;
            if (dbl_top && count_ff < lim_eff) begin
               count_in = count_ff + CW'(1);
            end
            if (bitcnt_ff == b62dc_pkg::BIT_LAST) begin
               state_in = S_EMIT;
               emit_in  = '0;
            end
         end
         S_INC: begin
            // advance the carry; grow or wrap when it leaves the top digit
            cell_op = b62dc_pkg::OP_INC;
            if (inc_top) begin
               count_in = (count_ff < lim_eff) ? count_ff + CW'(1) : CW'(1);
            end
            if (inc_vec == '0) begin
               state_in = S_EMIT;
               emit_in  = '0;
            end
         end
         S_EMIT: begin
            // send the top digit and rotate the row
            if (out_free) begin
               cell_op                = b62dc_pkg::OP_ROTATE;
               rsp_valid_in           = 1'b1;
               rsp_data_in.digit_char = b62dc_pkg::glyph(top_digit);
               rsp_data_in.final_char = emit_last;
               emit_in                = emit_ff + CW'(1);
               if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= b62dc_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bitcnt_ff   <= bitcnt_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIGITS))
      else $error("digit count above capacity");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> count_ff != '0)
      else $error("busy with an empty number");

   a_one_carry: assert property (@(posedge clock) disable iff (reset)
      $onehot0(inc_vec))
      else $error("more than one increment carry in flight");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> emit_ff < count_ff)
      else $error("readout index past the digit count");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && emit_last) |=> state_ff == S_IDLE)
      else $error("no return to idle after the last character");

endmodule
